// File: rtl/core/gb5_pkg.sv
// Shared types, constants and helpers for the 5x5 binomial blur stream unit.
// No dependencies; imported by every module of the block except gb5_ram.
package gb5_pkg;

    localparam int PIX_W     = 9;                 // pixel width
    localparam int COL_W     = 13;                // column / row counter width
    localparam int CFG_W     = 14;                // configuration data width
    localparam int CFG_IDX_W = 1;                 // configuration register index width
    localparam int N_TAPS    = 5;                 // kernel size
    localparam int N_LINES   = N_TAPS - 1;        // stored previous rows
    localparam int VSUM_W    = PIX_W + 4;         // vertical 1-4-6-4-1 sum
    localparam int SUM_W     = PIX_W + 8;         // full 5x5 sum
    localparam int WGT_W     = 3;
    localparam int LB_WIDTH  = N_LINES * PIX_W;   // one line memory word: a column of 4 rows
    localparam int MAX_WIDTH = 8192;

    localparam logic [CFG_W-1:0] DIM_MIN        = CFG_W'(5);
    localparam logic [CFG_W-1:0] WIDTH_MAX      = CFG_W'(MAX_WIDTH);
    localparam logic [CFG_W-1:0] HEIGHT_MAX     = CFG_W'(8192);
    localparam logic [CFG_W-1:0] WIDTH_DEFAULT  = CFG_W'(7680);
    localparam logic [CFG_W-1:0] HEIGHT_DEFAULT = CFG_W'(4320);

    localparam logic [WGT_W-1:0] C_BINOM [N_TAPS] = '{3'd1, 3'd4, 3'd6, 3'd4, 3'd1};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_reg_idx;

    // Position info that follows a request down the pipeline
    typedef struct packed {
        logic             emit;
        logic             last;
        logic [COL_W-1:0] col;
        logic [COL_W-1:0] row;
    } t_meta;

    function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                   input logic [CFG_W-1:0] hi);
        logic [CFG_W-1:0] r;
        if (v < DIM_MIN) begin
            r = DIM_MIN;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// File: rtl/core/gb5_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies. Read during write to the same address returns the old word.
module gb5_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/gb5_cell.sv
// One horizontal tap of the blur: adds weight * column sum to the partial sum
// handed over by its left neighbor. Depends on gb5_pkg.
module gb5_cell
    import gb5_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [WGT_W-1:0]  i_weight,
    input  logic [VSUM_W-1:0] i_vsum,
    input  logic [SUM_W-1:0]  i_acc,
    output logic [SUM_W-1:0]  o_acc
);

    logic [SUM_W-1:0] r_acc;
    logic [SUM_W-1:0] n_acc;

    always_comb begin
        n_acc = i_acc + SUM_W'(i_weight) * SUM_W'(i_vsum);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

// File: rtl/core/gaussian_blur_5x5_stream_unit.sv
// 5x5 binomial blur over a raster pixel stream. Takes one pixel per clock while not stalled
// and gives one blurred pixel for every interior position (two-pixel border dropped).
// o_valid rises once the pixel completing the neighborhood has passed three register
// stages: column read, tap chain, output. The sustained rate is one pixel per cycle while
// the output is not stalled; it is set by the line memory (8192 x 36), which does one read
// and one write of a whole column of four stored rows per pixel. Five cells in a chain
// form the horizontal taps on 1-4-6-4-1 column sums. No clearing pass: line memory words
// may be stale in the first four rows, but results are only emitted from row four on.
// Depends on gb5_pkg, gb5_ram, gb5_cell.
module gaussian_blur_5x5_stream_unit
    import gb5_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // pixel input
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [PIX_W-1:0]     i_pixel,
    input  logic                 i_frame_start,
    // result output
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [PIX_W-1:0]     o_blurred,
    output logic [COL_W-1:0]     o_out_column,
    output logic [COL_W-1:0]     o_out_row,
    output logic                 o_frame_done
);

    logic [CFG_W-1:0] r_width, r_height;
    logic [COL_W-1:0] r_col, r_row;

    logic             r_s1_valid;
    t_meta            r_s1_meta;
    logic [COL_W-1:0] r_s1_addr;
    logic [PIX_W-1:0] r_s1_pixel;
    logic             r_s1_fwd;
    logic [LB_WIDTH-1:0] r_s1_fwd_data;

    logic             r_s2_valid;
    t_meta            r_s2_meta;

    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_blurred;
    t_meta            r_out_meta;

    logic in_accept, out_free, en2, en1, s1_go, out_load;
    logic [COL_W-1:0] cur_col, cur_row, n_col, n_row;
    logic [CFG_W-1:0] col_inc, row_inc;
    t_meta            acc_meta;

    logic [LB_WIDTH-1:0] ram_rd, lb_word, wr_word;
    logic [VSUM_W-1:0]   vsum;
    logic [SUM_W-1:0]    acc_chain [N_TAPS+1];

    // ---------------- handshake ----------------
    assign out_free  = !r_out_valid || !i_stall;
    assign out_load  = r_s2_valid && out_free;
    assign en2       = !r_s2_valid || out_free;
    assign s1_go     = r_s1_valid && en2;
    assign en1       = !r_s1_valid || en2;
    assign in_accept = i_valid && en1;
    assign o_stall   = !en1;

    // ---------------- position counters ----------------
    always_comb begin
        cur_col = i_frame_start ? '0 : r_col;
        cur_row = i_frame_start ? '0 : r_row;

        acc_meta.emit = (cur_row >= COL_W'(4)) && (cur_col >= COL_W'(4))
                     && ({1'b0, cur_row} < r_height) && ({1'b0, cur_col} < r_width);
        acc_meta.last = ({1'b0, cur_row} == r_height - CFG_W'(1))
                     && ({1'b0, cur_col} == r_width - CFG_W'(1));
        acc_meta.col  = cur_col - COL_W'(2);
        acc_meta.row  = cur_row - COL_W'(2);

        col_inc = {1'b0, cur_col} + CFG_W'(1);
        row_inc = {1'b0, cur_row} + CFG_W'(1);
        if (col_inc >= r_width) begin
            n_col = '0;
            n_row = (row_inc >= r_height) ? '0 : row_inc[COL_W-1:0];
        end else begin
            n_col = col_inc[COL_W-1:0];
            n_row = cur_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_DEFAULT;
            r_height <= HEIGHT_DEFAULT;
        end else if (i_cfg_wr_en) begin
            case (t_reg_idx'(i_cfg_index))
                REG_IMAGE_WIDTH:  r_width  <= clamp_dim(i_cfg_data, WIDTH_MAX);
                REG_IMAGE_HEIGHT: r_height <= clamp_dim(i_cfg_data, HEIGHT_MAX);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ---------------- line memory ----------------
    gb5_ram #(
        .WIDTH(LB_WIDTH),
        .DEPTH(MAX_WIDTH)
    ) u_lines (
        .i_clk     (i_clk),
        .i_wr_en   (s1_go),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (wr_word),
        .i_rd_en   (in_accept),
        .i_rd_addr (cur_col),
        .o_rd_data (ram_rd)
    );

    // stage 1: column from memory (or bypassed from the previous write)
    always_comb begin
        lb_word = r_s1_fwd ? r_s1_fwd_data : ram_rd;
        // shift the column up one row, newest pixel at the bottom
        wr_word = {r_s1_pixel, lb_word[LB_WIDTH-1:PIX_W]};
        vsum = VSUM_W'(lb_word[0 +: PIX_W])
             + (VSUM_W'(lb_word[PIX_W +: PIX_W]) << 2)
             + (VSUM_W'(lb_word[2*PIX_W +: PIX_W]) << 2)
             + (VSUM_W'(lb_word[2*PIX_W +: PIX_W]) << 1)
             + (VSUM_W'(lb_word[3*PIX_W +: PIX_W]) << 2)
             + VSUM_W'(r_s1_pixel);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en1) begin
            r_s1_valid <= in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_meta     <= acc_meta;
            r_s1_addr     <= cur_col;
            r_s1_pixel    <= i_pixel;
            // memory read returns stale data when the same column is written now
            r_s1_fwd      <= s1_go && (r_s1_addr == cur_col);
            r_s1_fwd_data <= wr_word;
        end
    end

    // ---------------- horizontal tap chain ----------------
    assign acc_chain[0] = '0;

    for (genvar k = 0; k < N_TAPS; k++) begin : g_cell
        gb5_cell u_cell (
            .i_clk    (i_clk),
            .i_en     (s1_go),
            .i_weight (C_BINOM[k]),
            .i_vsum   (vsum),
            .i_acc    (acc_chain[k]),
            .o_acc    (acc_chain[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s1_go) begin
            r_s2_valid <= r_s1_meta.emit;
        end else if (out_load) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_s2_meta <= r_s1_meta;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_blurred <= acc_chain[N_TAPS][SUM_W-1:SUM_W-PIX_W];
            r_out_meta    <= r_s2_meta;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_blurred    = r_out_blurred;
    assign o_out_column = r_out_meta.col;
    assign o_out_row    = r_out_meta.row;
    assign o_frame_done = r_out_meta.last;

endmodule

// File: rtl/core/gb5_checker.sv
// Port-level checks for the blur stream unit, attached to it by bind.
// Depends on gb5_pkg and on gaussian_blur_5x5_stream_unit.
module gb5_checker
    import gb5_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_stall,
    input logic                 o_valid,
    input logic                 i_stall,
    input logic [PIX_W-1:0]     o_blurred,
    input logic [COL_W-1:0]     o_out_column,
    input logic [COL_W-1:0]     o_out_row,
    input logic                 o_frame_done
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_blurred) && $stable(o_out_column)
                               && $stable(o_out_row) && $stable(o_frame_done))
        else $error("result changed while stalled");

    // results only for interior pixels
    a_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out_column >= COL_W'(2)) && (o_out_row >= COL_W'(2)))
        else $error("result for a border pixel");

    // reset empties the pipeline and opens the input
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("pipeline not empty after reset");

    // with the pipeline drained and output taken, the input cannot be stalled
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_valid && !i_stall ##1 !i_valid && !i_stall |=> !o_stall)
        else $error("input stalled with no work in flight");

endmodule

bind gaussian_blur_5x5_stream_unit gb5_checker u_gb5_checker (.*);
